// File: sv/wscf_pkg.sv
// wscf_pkg: shared types, constants and lookup functions for the wheel speed
// command framer. No dependencies; compile first.
`default_nettype none

package wscf_pkg;

   localparam int SPEED_W   = 9;
   localparam int BYTE_W    = 8;
   localparam int CODE_W    = 16;
   localparam int MAG_W     = 7;
   localparam int SLOPE_W   = 12;
   localparam int PROD_W    = 18;
   localparam int DVD_W     = 15;
   localparam int RECIP_W   = 16;
   localparam int REC_W     = DVD_W + RECIP_W;
   localparam int QUOT_W    = 12;
   localparam int FRAME_LEN = 9;
   localparam int IDX_W     = $clog2(FRAME_LEN);
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

   localparam logic signed [SPEED_W-1:0] SPEED_MAX  = 9'sd144;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN  = -9'sd144;
   localparam logic signed [SPEED_W-1:0] KNEE_POS   = 9'sd40;
   localparam logic signed [SPEED_W-1:0] KNEE_NEG   = -9'sd40;

   localparam logic [SLOPE_W-1:0] SLOPE_POS_LOW = 12'd796;
   localparam logic [SLOPE_W-1:0] SLOPE_NEG_LOW = 12'd789;
   localparam logic [SLOPE_W-1:0] SLOPE_HIGH    = 12'd2312;

   // x/39 = (x * 53774) >> 21 exact for x < 2^15
   localparam logic [RECIP_W-1:0] RECIP_39 = 16'd53774;
   // x/104 = ((x >> 3) * 40330) >> 19 exact for x < 2^18
   localparam logic [RECIP_W-1:0] RECIP_13 = 16'd40330;

   localparam logic [CODE_W-1:0] OFS_POS_LOW  = 16'd70;
   localparam logic [CODE_W-1:0] OFS_NEG_LOW  = 16'd32845;
   localparam logic [CODE_W-1:0] OFS_POS_HIGH = 16'd888;
   localparam logic [CODE_W-1:0] OFS_NEG_HIGH = 16'd33656;

   localparam logic [BYTE_W-1:0] HDR1_RESET = 8'h02;
   localparam logic [BYTE_W-1:0] HDR2_RESET = 8'h09;
   localparam logic [BYTE_W-1:0] MODE_BYTE  = 8'h00;

   // register index, taken from paddr[2]
   localparam logic CSR_FIRST_HDR  = 1'b0;
   localparam logic CSR_SECOND_HDR = 1'b1;

   typedef enum logic [1:0] {
      REG_POS_LOW  = 2'd0,
      REG_NEG_LOW  = 2'd1,
      REG_POS_HIGH = 2'd2,
      REG_NEG_HIGH = 2'd3
   } region_type;

   // per-stage load enables of the speed map pipeline
   typedef struct packed {
      logic p1;
      logic p2;
      logic p3;
      logic p4;
   } adv_type;

   function automatic logic [SLOPE_W-1:0] slope_of(input region_type r);
      logic [SLOPE_W-1:0] s;
      case (r)
         REG_POS_LOW: s = SLOPE_POS_LOW;
         REG_NEG_LOW: s = SLOPE_NEG_LOW;
         default:     s = SLOPE_HIGH;
      endcase
      return s;
   endfunction

   function automatic logic [CODE_W-1:0] offset_of(input region_type r);
      logic [CODE_W-1:0] o;
      case (r)
         REG_POS_LOW:  o = OFS_POS_LOW;
         REG_NEG_LOW:  o = OFS_NEG_LOW;
         REG_POS_HIGH: o = OFS_POS_HIGH;
         default:      o = OFS_NEG_HIGH;
      endcase
      return o;
   endfunction

   function automatic logic is_high(input region_type r);
      return (r == REG_POS_HIGH) || (r == REG_NEG_HIGH);
   endfunction

endpackage

`default_nettype wire

// File: sv/wscf_req_if.sv
// wscf_req_if: valid/ready channel carrying one speed pair.
// Depends on wscf_pkg.
`default_nettype none

interface wscf_req_if
   import wscf_pkg::*;
   ();
   logic                       valid;
   logic                       ready;
   logic signed [SPEED_W-1:0]  motor1_speed;
   logic signed [SPEED_W-1:0]  motor2_speed;

   modport source (output valid, output motor1_speed, output motor2_speed, input ready);
   modport sink   (input valid, input motor1_speed, input motor2_speed, output ready);
endinterface

`default_nettype wire

// File: sv/wscf_rsp_if.sv
// wscf_rsp_if: valid/ready channel carrying one frame byte.
// Depends on wscf_pkg.
`default_nettype none

interface wscf_rsp_if
   import wscf_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [BYTE_W-1:0]  frame_byte;
   logic               last_byte;

   modport source (output valid, output frame_byte, output last_byte, input ready);
   modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: sv/wscf_speed_map.sv
// wscf_speed_map: four-stage datapath from one clamped wheel speed to its
// 16-bit motor code. Depends on wscf_pkg; valid bits live in the top level.
`default_nettype none

module wscf_speed_map
   import wscf_pkg::*;
(
   input  wire logic                       clock,
   input  wire adv_type                    adv,
   input  wire logic signed [SPEED_W-1:0]  speed,
   output      logic        [CODE_W-1:0]   code
);

   // stage 1: clamp, pick region, magnitude
   logic signed [SPEED_W-1:0] clamp;
   region_type                reg1_in,  reg1_ff;
   logic [MAG_W-1:0]          mag1_in,  mag1_ff;

   always_comb begin
      if (speed > SPEED_MAX) begin
         clamp = SPEED_MAX;
      end else if (speed < SPEED_MIN) begin
         clamp = SPEED_MIN;
      end else begin
         clamp = speed;
      end

      if (!clamp[SPEED_W-1]) begin
         if (clamp < KNEE_POS) begin
            reg1_in = REG_POS_LOW;
            mag1_in = MAG_W'(clamp);
         end else begin
            reg1_in = REG_POS_HIGH;
            mag1_in = MAG_W'(clamp - KNEE_POS);
         end
      end else begin
         if (clamp > KNEE_NEG) begin
            reg1_in = REG_NEG_LOW;
            mag1_in = MAG_W'(-clamp);
         end else begin
            reg1_in = REG_NEG_HIGH;
            mag1_in = MAG_W'(-clamp - KNEE_POS);
         end
      end
   end

   // stage 2: magnitude times slope
   region_type        reg2_ff;
   logic [PROD_W-1:0] prod2_in, prod2_ff;

   assign prod2_in = PROD_W'(19'(mag1_ff) * 19'(slope_of(reg1_ff)));

   // stage 3: multiply by reciprocal of the divisor
   region_type        reg3_ff;
   logic [DVD_W-1:0]  dvd;
   logic [RECIP_W-1:0] recip;
   logic [REC_W-1:0]  rec3_in, rec3_ff;

   always_comb begin
      if (is_high(reg2_ff)) begin
         dvd   = prod2_ff[PROD_W-1:3];
         recip = RECIP_13;
      end else begin
         dvd   = prod2_ff[DVD_W-1:0];
         recip = RECIP_39;
      end
      rec3_in = REC_W'(dvd) * REC_W'(recip);
   end

   // stage 4: take quotient, add region offset
   logic [QUOT_W-1:0] quot;
   logic [CODE_W-1:0] code4_in, code4_ff;

   always_comb begin
      if (is_high(reg3_ff)) begin
         quot = rec3_ff[REC_W-1:19];
      end else begin
         quot = QUOT_W'(rec3_ff[REC_W-1:21]);
      end
      code4_in = offset_of(reg3_ff) + CODE_W'(quot);
   end

   always_ff @(posedge clock) begin
      if (adv.p1) begin
         reg1_ff <= reg1_in;
         mag1_ff <= mag1_in;
      end
      if (adv.p2) begin
         reg2_ff  <= reg1_ff;
         prod2_ff <= prod2_in;
      end
      if (adv.p3) begin
         reg3_ff <= reg2_ff;
         rec3_ff <= rec3_in;
      end
      if (adv.p4) begin
         code4_ff <= code4_in;
      end
   end

   assign code = code4_ff;

endmodule

`default_nettype wire

// File: sv/wheel_speed_command_framer.sv
// wheel_speed_command_framer: turns a speed pair into a nine-byte motor
// command frame. Depends on wscf_pkg, wscf_req_if, wscf_rsp_if, wscf_speed_map.
// Path: a request passes map stages 1 to 4, the stage 5 frame register, the
// serializer and its byte output register; the checksum byte closes the frame.
// Throughput: set by the serializer, which sends one byte per cycle unless rsp
// stalls; up to five more pairs wait in the pipeline behind it.
// Reset (synchronous, active high) clears all valid bits, the serializer and
// sets the headers to 0x02 and 0x09.
`default_nettype none

module wheel_speed_command_framer
   import wscf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   wscf_req_if.sink                req_bus,
   wscf_rsp_if.source              rsp_bus,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [CSR_AW-1:0]  paddr,
   input  wire logic [CSR_DW-1:0]  pwdata,
   output      logic [CSR_DW-1:0]  prdata,
   output      logic               pready
);

   // ---------------------------------------------------------------
   // Configuration registers: headers, written on the APB access phase
   // ---------------------------------------------------------------
   logic [BYTE_W-1:0] hdr1_ff, hdr2_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr1_ff <= HDR1_RESET;
         hdr2_ff <= HDR2_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            CSR_FIRST_HDR:  hdr1_ff <= pwdata[BYTE_W-1:0];
            CSR_SECOND_HDR: hdr2_ff <= pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         CSR_FIRST_HDR:  prdata = CSR_DW'(hdr1_ff);
         CSR_SECOND_HDR: prdata = CSR_DW'(hdr2_ff);
         default:        prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------
   // Pipeline control: each stage loads when it is empty or its
   // content moves on; valid bits travel with the data.
   // ---------------------------------------------------------------
   logic    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic    mv1, mv2, mv3, mv4, mv5;
   logic    ser_take;
   adv_type adv;

   assign mv5 = !v5_ff || ser_take;
   assign mv4 = !v4_ff || mv5;
   assign mv3 = !v3_ff || mv4;
   assign mv2 = !v2_ff || mv3;
   assign mv1 = !v1_ff || mv2;

   assign req_bus.ready = mv1;

   assign adv.p1 = mv1;
   assign adv.p2 = mv2;
   assign adv.p3 = mv3;
   assign adv.p4 = mv4;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (mv1) v1_ff <= req_bus.valid;
         if (mv2) v2_ff <= v1_ff;
         if (mv3) v3_ff <= v2_ff;
         if (mv4) v4_ff <= v3_ff;
         if (mv5) v5_ff <= v4_ff;
      end
   end

   // ---------------------------------------------------------------
   // Speed to motor code, one map per wheel (stages 1 to 4)
   // ---------------------------------------------------------------
   logic [CODE_W-1:0] code1, code2;

   wscf_speed_map u_map1 (
      .clock (clock),
      .adv   (adv),
      .speed (req_bus.motor1_speed),
      .code  (code1)
   );

   wscf_speed_map u_map2 (
      .clock (clock),
      .adv   (adv),
      .speed (req_bus.motor2_speed),
      .code  (code2)
   );

   // ---------------------------------------------------------------
   // Stage 5: assemble the frame and its checksum
   // ---------------------------------------------------------------
   logic [BYTE_W-1:0] frm_in [FRAME_LEN];
   logic [BYTE_W-1:0] frm_ff [FRAME_LEN];

   always_comb begin
      frm_in[0] = hdr1_ff;
      frm_in[1] = hdr2_ff;
      frm_in[2] = code1[CODE_W-1:BYTE_W];
      frm_in[3] = code1[BYTE_W-1:0];
      frm_in[4] = code2[CODE_W-1:BYTE_W];
      frm_in[5] = code2[BYTE_W-1:0];
      frm_in[6] = MODE_BYTE;
      frm_in[7] = MODE_BYTE;
      // 8-bit wrapping sum of the first eight bytes
      frm_in[8] = frm_in[0] + frm_in[1] + frm_in[2] + frm_in[3]
                + frm_in[4] + frm_in[5] + frm_in[6] + frm_in[7];
   end

   always_ff @(posedge clock) begin
      if (mv5) begin
         frm_ff <= frm_in;
      end
   end

   // ---------------------------------------------------------------
   // Serializer: hold one frame, send a byte per rsp slot. A new frame
   // loads in the cycle the checksum byte goes out, so frames follow
   // each other without a gap.
   // ---------------------------------------------------------------
   logic [BYTE_W-1:0] ser_ff [FRAME_LEN];
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              busy_ff, busy_in;
   logic              load_out;
   logic              is_last;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   assign load_out = busy_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign is_last  = (idx_ff == LAST_IDX);
   assign ser_take = !busy_ff || (load_out && is_last);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (ser_take) begin
         // grab the next frame, or go idle when none waits
         busy_in = v5_ff;
         idx_in  = '0;
      end else if (load_out) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = ser_ff[idx_ff];
         rsp_last_in  = is_last;
      end else if (rsp_bus.ready) begin
         // drop the byte once the sink takes it
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take && v5_ff) begin
         ser_ff <= frm_ff;
      end
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.frame_byte = rsp_byte_ff;
   assign rsp_bus.last_byte  = rsp_last_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_idx_range : assert property (@(posedge clock) disable iff (reset)
      idx_ff <= LAST_IDX)
      else $error("serializer index past end of frame");

   a_idle_after_last : assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> $past(load_out && is_last))
      else $error("serializer went idle in the middle of a frame");

   a_frame_hold : assert property (@(posedge clock) disable iff (reset)
      (v5_ff && !mv5) |=> (v5_ff && $stable(frm_ff[8])))
      else $error("stalled frame stage lost or changed its frame");

   a_last_on_index : assert property (@(posedge clock) disable iff (reset)
      load_out |=> (rsp_last_ff == $past(is_last)))
      else $error("last_byte out of step with frame position");

   a_idx_reset_new : assert property (@(posedge clock) disable iff (reset)
      (ser_take && v5_ff) |=> (busy_ff && idx_ff == '0))
      else $error("new frame did not start at its first byte");

endmodule

`default_nettype wire
